// ----- rtl/dcts_pkg.sv -----
`default_nettype none
package dcts_pkg;

  localparam int MAX_TASKS_DEF = 1024;
  localparam int MAX_EDGES_DEF = 4096;
  localparam int MAX_DEPS_DEF  = 255;

  localparam int CMD_W = 3;
  localparam int ID_W  = 10;
  localparam int DEP_W = 8;
  localparam int CNT_W = 11;
  localparam int ST_W  = 3;
  localparam int LEN_W = 8;
  localparam logic [LEN_W-1:0] LEN_MAX = 8'd255;
  localparam logic [CNT_W-1:0] TOTAL_MAX = 11'h7ff;

  localparam logic [CMD_W-1:0] CMD_LOAD_TASK = 3'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD_EDGE = 3'd1;
  localparam logic [CMD_W-1:0] CMD_START     = 3'd2;
  localparam logic [CMD_W-1:0] CMD_REMOTE    = 3'd3;
  localparam logic [CMD_W-1:0] CMD_ADVANCE   = 3'd4;

  localparam logic [ST_W-1:0] ST_OK       = 3'd0;
  localparam logic [ST_W-1:0] ST_DISPATCH = 3'd1;
  localparam logic [ST_W-1:0] ST_NONE     = 3'd2;
  localparam logic [ST_W-1:0] ST_DONE     = 3'd3;
  localparam logic [ST_W-1:0] ST_ERR      = 3'd4;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [ID_W-1:0]  task_id;
    logic [DEP_W-1:0] dep_count;
    logic [ID_W-1:0]  succ_id;
  } in_item_t;

  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic [ID_W-1:0]  issued_task;
    logic [CNT_W-1:0] completed_total;
    logic [CNT_W-1:0] ready_depth;
  } out_item_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DECODE, S_INIT_RD, S_INIT_WR, S_REM_WR, S_LIST_RD,
    S_EDGE_CHK, S_SUCC_RD, S_SUCC_WR, S_RETIRE, S_RESULT
  } state_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_CLEAR, OP_LATCH, OP_LOAD_TASK, OP_LOAD_EDGE, OP_START,
    OP_INIT_RD, OP_INIT_WR, OP_REM_RD, OP_REM_WR, OP_POP, OP_LIST_RD,
    OP_EDGE_RD, OP_SUCC_RD, OP_SUCC_WR, OP_RETIRE, OP_BAD, OP_RESULT
  } dp_op_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic tid_ok;
    logic n_zero;
    logic idx_last;
    logic clr_last;
    logic stack_empty;
    logic edge_more;
    logic succ_ok;
    logic out_free;
  } dp_stat_t;

endpackage
`default_nettype wire

// ----- rtl/dcts_ctrl.sv -----
`default_nettype none
module dcts_ctrl
  import dcts_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire dp_stat_t stat,
  output dp_op_t        op
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR:    if (stat.clr_last) state_next = S_IDLE;
      S_IDLE:     if (in_valid) state_next = S_DECODE;
      S_DECODE: begin
        unique case (stat.cmd)
          CMD_START:   state_next = stat.n_zero ? S_RESULT : S_INIT_RD;
          CMD_REMOTE:  state_next = stat.tid_ok ? S_REM_WR : S_RESULT;
          CMD_ADVANCE: state_next = stat.stack_empty ? S_RESULT : S_LIST_RD;
          default:     state_next = S_RESULT;
        endcase
      end
      S_INIT_RD:  state_next = S_INIT_WR;
      S_INIT_WR:  state_next = stat.idx_last ? S_RESULT : S_INIT_RD;
      S_REM_WR:   state_next = S_RESULT;
      S_LIST_RD:  state_next = S_EDGE_CHK;
      S_EDGE_CHK: state_next = stat.edge_more ? S_SUCC_RD : S_RETIRE;
      S_SUCC_RD:  state_next = stat.succ_ok ? S_SUCC_WR : S_EDGE_CHK;
      S_SUCC_WR:  state_next = S_EDGE_CHK;
      S_RETIRE:   state_next = S_RESULT;
      S_RESULT:   if (stat.out_free) state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  always_comb begin
    op = OP_NONE;
    in_ready = 1'b0;
    unique case (state)
      S_CLEAR: op = OP_CLEAR;
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) op = OP_LATCH;
      end
      S_DECODE: begin
        unique case (stat.cmd)
          CMD_LOAD_TASK: op = OP_LOAD_TASK;
          CMD_LOAD_EDGE: op = OP_LOAD_EDGE;
          CMD_START:     op = OP_START;
          CMD_REMOTE:    op = OP_REM_RD;
          CMD_ADVANCE:   op = OP_POP;
          default:       op = OP_BAD;
        endcase
      end
      S_INIT_RD:  op = OP_INIT_RD;
      S_INIT_WR:  op = OP_INIT_WR;
      S_REM_WR:   op = OP_REM_WR;
      S_LIST_RD:  op = OP_LIST_RD;
      S_EDGE_CHK: op = OP_EDGE_RD;
      S_SUCC_RD:  op = OP_SUCC_RD;
      S_SUCC_WR:  op = OP_SUCC_WR;
      S_RETIRE:   op = OP_RETIRE;
      S_RESULT:   if (stat.out_free) op = OP_RESULT;
      default:    op = OP_NONE;
    endcase
  end

`ifndef SYNTHESIS
  a_result_free: assert property (@(posedge clk) disable iff (rst)
    (op == OP_RESULT) |-> stat.out_free) else $error("result loaded while output busy");
  a_accept_idle: assert property (@(posedge clk) disable iff (rst)
    (op == OP_LATCH) |=> (state == S_DECODE)) else $error("accept did not decode");
  a_clear_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR && stat.clr_last) |=> in_ready) else $error("clear pass stuck");
`endif

endmodule
`default_nettype wire

// ----- rtl/dcts_dp.sv -----
`default_nettype none
module dcts_dp
  import dcts_pkg::*;
#(
  parameter int MAX_TASKS = MAX_TASKS_DEF,
  parameter int MAX_EDGES = MAX_EDGES_DEF,
  parameter int MAX_DEPS  = MAX_DEPS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire dp_op_t           op,
  output dp_stat_t              stat,
  input  wire in_item_t         in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output out_item_t             out_data,
  input  wire logic             cfg_we,
  input  wire logic [CNT_W-1:0] cfg_data
);

  localparam int TW = $clog2(MAX_TASKS);
  localparam int CW = $clog2(MAX_TASKS + 1);
  localparam int EW = $clog2(MAX_EDGES);
  localparam int FW = $clog2(MAX_EDGES + 1);

  logic [DEP_W-1:0] init_mem  [MAX_TASKS];
  logic [EW-1:0]    start_mem [MAX_TASKS];
  logic [LEN_W-1:0] len_mem   [MAX_TASKS];
  logic [ID_W-1:0]  store_mem [MAX_EDGES];
  logic [DEP_W-1:0] rem_mem   [MAX_TASKS];
  logic             fin_mem   [MAX_TASKS];
  logic [TW-1:0]    stack_mem [MAX_TASKS];

  logic [DEP_W-1:0] init_q, rem_q;
  logic [EW-1:0]    start_q;
  logic [LEN_W-1:0] len_q;
  logic [ID_W-1:0]  store_q;
  logic             fin_q;
  logic [TW-1:0]    stack_q;

  logic [CNT_W-1:0] task_count;
  logic [CW-1:0]    top;
  logic [CNT_W-1:0] total;
  logic [FW-1:0]    fill;
  logic [ID_W-1:0]  last_src;
  logic [LEN_W-1:0] cur_len;
  logic [TW-1:0]    idx;

  in_item_t         item;
  logic [ST_W-1:0]  res_st;
  logic [TW-1:0]    issued;
  logic [LEN_W-1:0] k;

  logic [CW-1:0]    n;
  logic [TW-1:0]    tid_a, succ_a;
  logic             tid_ok, ids_ok, edge_ok, edge_new, succ_ok, edge_more;
  logic [LEN_W-1:0] new_len;
  logic [DEP_W-1:0] dep_sat;
  logic [31:0]      pos;

  logic             init_we, init_re, start_we, len_we, store_we, store_re;
  logic             rem_we, rem_re, fin_we, fin_wd, list_re, stack_re, push_en;
  logic [TW-1:0]    init_a, len_wa, rem_wa, rem_ra, fin_wa, list_ra, stack_ra, push_val;
  logic [LEN_W-1:0] len_wd;
  logic [DEP_W-1:0] rem_wd;
  logic [EW-1:0]    store_ra;
  logic             push_ok;

  assign n = (32'(task_count) > MAX_TASKS) ? CW'(MAX_TASKS) : CW'(task_count);
  assign tid_a   = TW'(item.task_id);
  assign succ_a  = TW'(store_q);
  assign tid_ok  = 32'(item.task_id) < 32'(n);
  assign ids_ok  = tid_ok && (32'(item.succ_id) < 32'(n));
  assign edge_new = (fill == '0) || (item.task_id != last_src);
  assign edge_ok = ids_ok && (32'(fill) < MAX_EDGES)
                   && !((fill != '0) && (item.task_id < last_src))
                   && !(!edge_new && (cur_len == LEN_MAX));
  assign new_len = edge_new ? LEN_W'(1) : cur_len + LEN_W'(1);
  assign dep_sat = (32'(item.dep_count) > MAX_DEPS) ? DEP_W'(MAX_DEPS) : item.dep_count;
  assign pos = 32'(start_q) + 32'(k);
  assign edge_more = (k < len_q) && (pos < MAX_EDGES);
  assign succ_ok = 32'(store_q) < 32'(n);
  assign push_ok = push_en && (32'(top) < MAX_TASKS);

  assign stat.cmd         = item.cmd;
  assign stat.tid_ok      = tid_ok;
  assign stat.n_zero      = (n == '0);
  assign stat.idx_last    = (32'(idx) + 1) == 32'(n);
  assign stat.clr_last    = 32'(idx) == (MAX_TASKS - 1);
  assign stat.stack_empty = (top == '0);
  assign stat.edge_more   = edge_more;
  assign stat.succ_ok     = succ_ok;
  assign stat.out_free    = !out_valid || out_ready;

  // memory port steering
  always_comb begin
    init_we = 1'b0; init_re = 1'b0; init_a = idx;
    start_we = 1'b0; len_we = 1'b0; len_wa = idx; len_wd = '0;
    store_we = 1'b0; store_re = 1'b0; store_ra = EW'(pos);
    rem_we = 1'b0; rem_wa = tid_a; rem_wd = rem_q - DEP_W'(1);
    rem_re = 1'b0; rem_ra = tid_a;
    fin_we = 1'b0; fin_wa = idx; fin_wd = 1'b0;
    list_re = 1'b0; list_ra = stack_q;
    stack_re = 1'b0; stack_ra = TW'(top - CW'(1));
    push_en = 1'b0; push_val = tid_a;
    case (op)
      OP_CLEAR: len_we = 1'b1;
      OP_LOAD_TASK: begin
        init_we = tid_ok;
        init_a  = tid_a;
      end
      OP_LOAD_EDGE: begin
        len_we   = edge_ok;
        len_wa   = tid_a;
        len_wd   = new_len;
        store_we = edge_ok;
        start_we = edge_ok && edge_new;
      end
      OP_INIT_RD: init_re = 1'b1;
      OP_INIT_WR: begin
        rem_we   = 1'b1;
        rem_wa   = idx;
        rem_wd   = init_q;
        fin_we   = 1'b1;
        push_en  = (init_q == '0);
        push_val = idx;
      end
      OP_REM_RD: rem_re = 1'b1;
      OP_REM_WR: begin
        rem_we  = (rem_q != '0);
        push_en = (rem_q == DEP_W'(1)) && !fin_q;
      end
      OP_POP:     stack_re = (top != '0);
      OP_LIST_RD: list_re = 1'b1;
      OP_EDGE_RD: store_re = edge_more;
      OP_SUCC_RD: begin
        rem_re = succ_ok;
        rem_ra = succ_a;
      end
      OP_SUCC_WR: begin
        rem_we   = (rem_q != '0);
        rem_wa   = succ_a;
        push_en  = (rem_q == DEP_W'(1)) && !fin_q;
        push_val = succ_a;
      end
      OP_RETIRE: begin
        fin_we = 1'b1;
        fin_wa = issued;
        fin_wd = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (init_we) init_mem[init_a] <= dep_sat;
    if (init_re) init_q <= init_mem[init_a];
    if (start_we) start_mem[tid_a] <= EW'(fill);
    if (len_we) len_mem[len_wa] <= len_wd;
    if (list_re) begin
      start_q <= start_mem[list_ra];
      len_q   <= len_mem[list_ra];
    end
    if (store_we) store_mem[EW'(fill)] <= item.succ_id;
    if (store_re) store_q <= store_mem[store_ra];
    if (rem_we) rem_mem[rem_wa] <= rem_wd;
    if (fin_we) fin_mem[fin_wa] <= fin_wd;
    if (rem_re) begin
      rem_q <= rem_mem[rem_ra];
      fin_q <= fin_mem[rem_ra];
    end
    if (push_ok) stack_mem[TW'(top)] <= push_val;
    if (stack_re) stack_q <= stack_mem[stack_ra];
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      task_count <= '0;
      top        <= '0;
      total      <= '0;
      fill       <= '0;
      last_src   <= '0;
      cur_len    <= '0;
      idx        <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we) task_count <= cfg_data;
      if (op == OP_RESULT) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (push_ok) top <= top + CW'(1);
      case (op)
        OP_CLEAR, OP_INIT_WR: idx <= idx + TW'(1);
        OP_LOAD_EDGE: begin
          if (edge_ok) begin
            fill     <= fill + FW'(1);
            last_src <= item.task_id;
            cur_len  <= new_len;
          end
        end
        OP_START: begin
          top   <= '0;
          total <= '0;
          idx   <= '0;
        end
        OP_POP:    if (top != '0) top <= top - CW'(1);
        OP_RETIRE: if (total != TOTAL_MAX) total <= total + CNT_W'(1);
        default: ;
      endcase
    end
  end

  // item and result payload
  always_ff @(posedge clk) begin
    case (op)
      OP_LATCH:     item <= in_data;
      OP_LOAD_TASK: res_st <= tid_ok ? ST_OK : ST_ERR;
      OP_LOAD_EDGE: res_st <= edge_ok ? ST_OK : ST_ERR;
      OP_START:     res_st <= ST_OK;
      OP_REM_RD:    res_st <= tid_ok ? ST_OK : ST_ERR;
      OP_REM_WR:    if (rem_q == '0) res_st <= ST_ERR;
      OP_POP: begin
        if (top != '0) begin
          res_st <= ST_DISPATCH;
        end else begin
          res_st <= (32'(total) == 32'(n)) ? ST_DONE : ST_NONE;
        end
      end
      OP_LIST_RD: begin
        issued <= stack_q;
        k      <= '0;
      end
      OP_SUCC_RD: if (!succ_ok) k <= k + LEN_W'(1);
      OP_SUCC_WR: k <= k + LEN_W'(1);
      OP_BAD:     res_st <= ST_ERR;
      OP_RESULT: begin
        out_data.status          <= res_st;
        out_data.issued_task     <= (res_st == ST_DISPATCH) ? ID_W'(issued) : '0;
        out_data.completed_total <= total;
        out_data.ready_depth     <= CNT_W'(top);
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_top_bound: assert property (@(posedge clk) disable iff (rst)
    32'(top) <= MAX_TASKS) else $error("ready stack overflow");
  a_fill_mono: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> fill >= $past(fill)) else $error("edge fill went back");
  a_pop_dec: assert property (@(posedge clk) disable iff (rst)
    (op == OP_POP && top != '0) |=> top == $past(top) - CW'(1))
    else $error("pop did not shrink stack");
`endif

endmodule
`default_nettype wire

// ----- rtl/dependency_count_task_scheduler_unit.sv -----
`default_nettype none
// start visits every task; advance pops a ready task, if any, and walks each of its successors
// throughput: one command at a time; an item is accepted once the previous result is registered
// rate is set by the single read port of the dependency-count memory in the successor walk
// reset: synchronous, clears control; then a clearing pass over every entry of the
// successor length table, with no transfer accepted until it ends
module dependency_count_task_scheduler_unit
  import dcts_pkg::*;
#(
  parameter int MAX_TASKS = MAX_TASKS_DEF,
  parameter int MAX_EDGES = MAX_EDGES_DEF,
  parameter int MAX_DEPS  = MAX_DEPS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire in_item_t         in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output out_item_t             out_data,
  input  wire logic             cfg_we,
  input  wire logic [CNT_W-1:0] cfg_data
);

  dp_op_t   op;
  dp_stat_t stat;

  dcts_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .op       (op)
  );

  dcts_dp #(
    .MAX_TASKS (MAX_TASKS),
    .MAX_EDGES (MAX_EDGES),
    .MAX_DEPS  (MAX_DEPS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .op        (op),
    .stat      (stat),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data)
  );

endmodule
`default_nettype wire
